@@ rtl/tlc_pkg.sv @@
package tlc_pkg;

  // Fixed field widths.
  localparam int ADDR_W     = 32;
  localparam int STAMP_W    = 32;
  localparam int LAT_W      = 18;
  localparam int WB_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int L1_LAT_W   = 8;
  localparam int L2_LAT_W   = 8;
  localparam int MEM_DLY_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_L1_LAT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L2_LAT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_DELAY = 2'd2;

  // Register reset values.
  localparam logic [L1_LAT_W-1:0]  L1_LAT_RST  = 8'd1;
  localparam logic [L2_LAT_W-1:0]  L2_LAT_RST  = 8'd4;
  localparam logic [MEM_DLY_W-1:0] MEM_DLY_RST = 16'd200;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic finish;
  } tlc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic scan_last;
  } tlc_sts_t;

endpackage

@@ rtl/two_level_cache_access_model_top.sv @@
// Two-level set-associative cache access model with timestamp LRU replacement.
// Each input word is one access; each gives exactly one result word with the
// latency charged, the miss flags and the writeback count. After reset the
// block clears both set memories, one set of each level per cycle, until every
// set of the larger level is cleared; in_ready stays low meanwhile, while
// configuration writes are taken at any time. An access reads the set rows of
// both levels when it is accepted, scans the ways in turn in a scan that both
// levels share, and then writes the rows back and registers the result; this
// last step waits while an earlier result is still unread at the output.
// One access is in progress at a time; a finished result may wait at the
// output while the next access is accepted. Configure only while idle.
module two_level_cache_access_model_top #(
  parameter int LINE_BITS       = 6,
  parameter int FIRST_SET_BITS  = 8,
  parameter int FIRST_WAYS      = 4,
  parameter int SECOND_SET_BITS = 10,
  parameter int SECOND_WAYS     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [tlc_pkg::ADDR_W-1:0]     in_address,
  input  logic [tlc_pkg::STAMP_W-1:0]    in_timestamp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tlc_pkg::LAT_W-1:0]      out_latency,
  output logic                           out_first_miss,
  output logic                           out_second_miss,
  output logic [tlc_pkg::WB_W-1:0]       out_writebacks,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tlc_pkg::*;

  tlc_cmd_t cmd;
  tlc_sts_t sts;

  // Registers accept a word in every cycle.
  assign cfg_ready = 1'b1;

  tlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlc_dp #(
    .LINE_BITS       (LINE_BITS),
    .FIRST_SET_BITS  (FIRST_SET_BITS),
    .FIRST_WAYS      (FIRST_WAYS),
    .SECOND_SET_BITS (SECOND_SET_BITS),
    .SECOND_WAYS     (SECOND_WAYS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_address      (in_address),
    .in_timestamp    (in_timestamp),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_latency     (out_latency),
    .out_first_miss  (out_first_miss),
    .out_second_miss (out_second_miss),
    .out_writebacks  (out_writebacks)
  );

endmodule

@@ rtl/tlc_ctrl.sv @@
module tlc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tlc_pkg::tlc_sts_t sts,
  output tlc_pkg::tlc_cmd_t cmd
);
  import tlc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   can_finish;

  assign in_ready   = in_ready_r;
  assign out_valid  = out_valid_r;
  assign can_finish = !out_valid_r || out_ready;

  // Commands follow the state and the handshakes.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR:  cmd.clear  = 1'b1;
      ST_IDLE:   cmd.load   = in_valid && in_ready_r;
      ST_SCAN:   cmd.step   = 1'b1;
      ST_FINISH: cmd.finish = can_finish;
      default:   cmd = '0;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.clear_last) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= ST_SCAN;
            in_ready_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (sts.scan_last) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (can_finish) begin
            state_r     <= ST_IDLE;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

endmodule

@@ rtl/tlc_dp.sv @@
module tlc_dp #(
  parameter int LINE_BITS       = 6,
  parameter int FIRST_SET_BITS  = 8,
  parameter int FIRST_WAYS      = 4,
  parameter int SECOND_SET_BITS = 10,
  parameter int SECOND_WAYS     = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_action,
  input  logic [tlc_pkg::ADDR_W-1:0]        in_address,
  input  logic [tlc_pkg::STAMP_W-1:0]       in_timestamp,
  input  logic                              cfg_we,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  tlc_pkg::tlc_cmd_t                 cmd,
  output tlc_pkg::tlc_sts_t                 sts,
  output logic [tlc_pkg::LAT_W-1:0]         out_latency,
  output logic                              out_first_miss,
  output logic                              out_second_miss,
  output logic [tlc_pkg::WB_W-1:0]          out_writebacks
);
  import tlc_pkg::*;

  localparam int L1_SETS = 1 << FIRST_SET_BITS;
  localparam int L2_SETS = 1 << SECOND_SET_BITS;
  localparam int T1      = ADDR_W - LINE_BITS - FIRST_SET_BITS;
  localparam int T2      = ADDR_W - LINE_BITS - SECOND_SET_BITS;
  localparam int MAXW    = (FIRST_WAYS > SECOND_WAYS) ? FIRST_WAYS : SECOND_WAYS;
  localparam int SW      = (MAXW > 1) ? $clog2(MAXW) : 1;
  localparam int CW      = (FIRST_SET_BITS > SECOND_SET_BITS) ? FIRST_SET_BITS
                                                              : SECOND_SET_BITS;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic               dirty;
    logic               valid;
    logic [T1-1:0]      tag;
  } l1_way_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic               dirty;
    logic               valid;
    logic [T2-1:0]      tag;
  } l2_way_t;

  // Set memories: one row holds every way of a set.
  l1_way_t [FIRST_WAYS-1:0]  l1_mem [L1_SETS];
  l2_way_t [SECOND_WAYS-1:0] l2_mem [L2_SETS];

  l1_way_t [FIRST_WAYS-1:0]  row1_r, row1_nxt;
  l2_way_t [SECOND_WAYS-1:0] row2_r, row2_nxt;

  logic                 action_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [STAMP_W-1:0]   now_r;
  logic [SW-1:0]        scan_r;
  logic [CW-1:0]        clr_r;

  logic [L1_LAT_W-1:0]  l1_lat_r;
  logic [L2_LAT_W-1:0]  l2_lat_r;
  logic [MEM_DLY_W-1:0] mem_dly_r;

  // Scan results per level: hit, first invalid, first lowest stamp, first tag match.
  logic               hit1_f, inv1_f, mt1_f, hit2_f, inv2_f, mt2_f;
  logic [SW-1:0]      hit1_i, inv1_i, min1_i, mt1_i, hit2_i, inv2_i, min2_i, mt2_i;
  logic [STAMP_W-1:0] min1_s, min2_s;

  logic [FIRST_SET_BITS-1:0]  set1;
  logic [SECOND_SET_BITS-1:0] set2;
  logic [T1-1:0]              tag1;
  logic [T2-1:0]              tag2;

  l1_way_t w1;
  l2_way_t w2;
  logic    act1, act2;

  logic          miss1, miss2, vd1, vd2, has1, has2;
  logic [SW-1:0] vic1, vic2, m1, m2;
  logic [LAT_W-1:0] lat_nxt;
  logic [WB_W-1:0]  wb_nxt;

  assign set1 = addr_r[LINE_BITS +: FIRST_SET_BITS];
  assign set2 = addr_r[LINE_BITS +: SECOND_SET_BITS];
  assign tag1 = addr_r[LINE_BITS + FIRST_SET_BITS +: T1];
  assign tag2 = addr_r[LINE_BITS + SECOND_SET_BITS +: T2];

  assign sts.clear_last = (clr_r == {CW{1'b1}});
  assign sts.scan_last  = (scan_r == SW'(MAXW - 1));

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_lat_r  <= L1_LAT_RST;
      l2_lat_r  <= L2_LAT_RST;
      mem_dly_r <= MEM_DLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_L1_LAT:    l1_lat_r  <= cfg_wdata[L1_LAT_W-1:0];
        REG_L2_LAT:    l2_lat_r  <= cfg_wdata[L2_LAT_W-1:0];
        REG_MEM_DELAY: mem_dly_r <= cfg_wdata[MEM_DLY_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass counter and way scan counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      scan_r <= '0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + CW'(1);
      end
      if (cmd.load) begin
        scan_r <= '0;
      end else if (cmd.step) begin
        scan_r <= scan_r + SW'(1);
      end
    end
  end

  // Set memories: clearing pass, row read on accept, row write-back at the end.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      l1_mem[clr_r[FIRST_SET_BITS-1:0]]  <= '0;
      l2_mem[clr_r[SECOND_SET_BITS-1:0]] <= '0;
    end else if (cmd.finish) begin
      l1_mem[set1] <= row1_nxt;
      l2_mem[set2] <= row2_nxt;
    end
    if (cmd.load) begin
      row1_r   <= l1_mem[in_address[LINE_BITS +: FIRST_SET_BITS]];
      row2_r   <= l2_mem[in_address[LINE_BITS +: SECOND_SET_BITS]];
      action_r <= in_action;
      addr_r   <= in_address;
      now_r    <= in_timestamp;
    end
  end

  // Pick the way under scan in each level.
  always_comb begin
    w1 = '0;
    w2 = '0;
    for (int j = 0; j < FIRST_WAYS; j++) begin
      if (SW'(j) == scan_r) w1 = row1_r[j];
    end
    for (int j = 0; j < SECOND_WAYS; j++) begin
      if (SW'(j) == scan_r) w2 = row2_r[j];
    end
    act1 = ({1'b0, scan_r} < (SW + 1)'(FIRST_WAYS));
    act2 = ({1'b0, scan_r} < (SW + 1)'(SECOND_WAYS));
  end

  // One way of each level per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit1_f <= 1'b0; inv1_f <= 1'b0; mt1_f <= 1'b0;
      hit2_f <= 1'b0; inv2_f <= 1'b0; mt2_f <= 1'b0;
    end else if (cmd.step) begin
      if (act1) begin
        if (!hit1_f && w1.valid && w1.tag == tag1) begin
          hit1_f <= 1'b1; hit1_i <= scan_r;
        end
        if (!inv1_f && !w1.valid) begin
          inv1_f <= 1'b1; inv1_i <= scan_r;
        end
        if (scan_r == '0 || w1.stamp < min1_s) begin
          min1_s <= w1.stamp; min1_i <= scan_r;
        end
        if (!mt1_f && w1.tag == tag1) begin
          mt1_f <= 1'b1; mt1_i <= scan_r;
        end
      end
      if (act2) begin
        if (!hit2_f && w2.valid && w2.tag == tag2) begin
          hit2_f <= 1'b1; hit2_i <= scan_r;
        end
        if (!inv2_f && !w2.valid) begin
          inv2_f <= 1'b1; inv2_i <= scan_r;
        end
        if (scan_r == '0 || w2.stamp < min2_s) begin
          min2_s <= w2.stamp; min2_i <= scan_r;
        end
        if (!mt2_f && w2.tag == tag2) begin
          mt2_f <= 1'b1; mt2_i <= scan_r;
        end
      end
    end
  end

  // Victims, write target ways and the updated rows.
  always_comb begin
    miss1 = !hit1_f;
    miss2 = miss1 && !hit2_f;
    vic1  = inv1_f ? inv1_i : min1_i;
    vic2  = inv2_f ? inv2_i : min2_i;
    // A filled victim matches the tag too, so the first match may be the victim.
    m1    = (miss1 && !(mt1_f && mt1_i < vic1)) ? vic1 : mt1_i;
    m2    = (miss2 && !(mt2_f && mt2_i < vic2)) ? vic2 : mt2_i;
    has1  = miss1 || mt1_f;
    has2  = miss2 || mt2_f;
    vd1   = 1'b0;
    vd2   = 1'b0;
    for (int j = 0; j < FIRST_WAYS; j++) begin
      row1_nxt[j] = row1_r[j];
      if (SW'(j) == vic1) vd1 = row1_r[j].dirty;
      if (!miss1 && SW'(j) == hit1_i) row1_nxt[j].stamp = now_r;
      if (miss1 && SW'(j) == vic1) row1_nxt[j] = '{stamp: now_r, dirty: 1'b0,
                                                   valid: 1'b1, tag: tag1};
      if (action_r && has1 && SW'(j) == m1) row1_nxt[j].dirty = 1'b1;
    end
    for (int j = 0; j < SECOND_WAYS; j++) begin
      row2_nxt[j] = row2_r[j];
      if (SW'(j) == vic2) vd2 = row2_r[j].dirty;
      if (miss1 && hit2_f && SW'(j) == hit2_i) row2_nxt[j].stamp = now_r;
      if (miss2 && SW'(j) == vic2) row2_nxt[j] = '{stamp: now_r, dirty: 1'b0,
                                                   valid: 1'b1, tag: tag2};
      if (action_r && has2 && SW'(j) == m2) row2_nxt[j].valid = 1'b0;
    end
    wb_nxt  = WB_W'(miss1 && vd1) + WB_W'(miss2 && vd2);
    lat_nxt = LAT_W'(l1_lat_r)
            + (miss1 ? LAT_W'(l2_lat_r) : '0)
            + ((miss1 && vd1) ? LAT_W'(mem_dly_r) : '0)
            + ((miss2 && vd2) ? LAT_W'(mem_dly_r) : '0);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_latency     <= lat_nxt;
      out_first_miss  <= miss1;
      out_second_miss <= miss2;
      out_writebacks  <= wb_nxt;
    end
  end

endmodule

@@ rtl/tlc_checker.sv @@
module tlc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_first_miss,
  input logic                      out_second_miss,
  input logic [tlc_pkg::WB_W-1:0]  out_writebacks
);
  import tlc_pkg::*;

  // A waiting result word is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn before it was taken");

  // Reset starts the clearing pass, so no word is taken just after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // One access at a time: the word after an accepted one waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after an accept");

  // The second level is only looked up after a first level miss.
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_miss |-> out_first_miss)
    else $error("second level miss without first level miss");

  // A first level hit evicts nothing.
  a_hit_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_first_miss |-> out_writebacks == '0)
    else $error("writeback reported on a first level hit");

endmodule

bind two_level_cache_access_model_top tlc_checker u_tlc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_first_miss  (out_first_miss),
  .out_second_miss (out_second_miss),
  .out_writebacks  (out_writebacks)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tlc_pkg::*;

  localparam int L1_SETS = 256;
  localparam int L1_WAYS = 4;
  localparam int L2_SETS = 1024;
  localparam int L2_WAYS = 8;
  localparam int L2_BASE = L1_SETS * L1_WAYS;
  localparam int N_LINES = L2_BASE + L2_SETS * L2_WAYS;

  typedef struct {
    logic [LAT_W-1:0] latency;
    logic             first_miss;
    logic             second_miss;
    logic [WB_W-1:0]  writebacks;
  } access_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = 1'b0;
  logic [ADDR_W-1:0]     in_address = '0;
  logic [STAMP_W-1:0]    in_timestamp = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LAT_W-1:0]      out_latency;
  logic                  out_first_miss;
  logic                  out_second_miss;
  logic [WB_W-1:0]       out_writebacks;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  two_level_cache_access_model_top uut (.*);

  always #5 clk = ~clk;

  // Mirror of both cache levels; the second level sits above the first.
  logic [31:0] line_tag [N_LINES];
  logic        line_valid [N_LINES];
  logic        line_dirty [N_LINES];
  logic [31:0] line_stamp [N_LINES];
  logic [L1_LAT_W-1:0]  l1_lat = L1_LAT_RST;
  logic [L2_LAT_W-1:0]  l2_lat = L2_LAT_RST;
  logic [MEM_DLY_W-1:0] mem_dly = MEM_DLY_RST;

  access_result_t pending_results[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_max = 4;
  int stall_pct = 30;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  logic [31:0] clock_now = 0;

  initial begin
    for (int i = 0; i < N_LINES; i++) begin
      line_tag[i] = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_stamp[i] = '0;
    end
  end

  // Scan one set: a hit refreshes the stamp, a miss returns the first invalid way or else the LRU victim.
  function automatic bit probe_level(bit second, logic [31:0] addr, logic [31:0] now,
                                     output int victim);
    int base;
    int ways;
    int cand;
    int p;
    logic [31:0] tag;
    logic [31:0] lowest;
    ways = second ? L2_WAYS : L1_WAYS;
    base = second ? L2_BASE + int'((addr >> 6) & 32'd1023) * L2_WAYS
                  : int'((addr >> 6) & 32'd255) * L1_WAYS;
    tag = second ? addr >> 16 : addr >> 14;
    cand = base;
    lowest = '1;
    victim = base;
    for (int i = 0; i < ways; i++) begin
      p = base + i;
      if (line_tag[p] == tag && line_valid[p]) begin
        line_stamp[p] = now;
        return 1'b1;
      end
      if (line_valid[cand] && (lowest > line_stamp[p] || !line_valid[p])) begin
        cand = p;
        lowest = line_stamp[p];
      end
    end
    victim = cand;
    return 1'b0;
  endfunction

  // Allocate a line; a dirty victim costs the memory delay and one writeback.
  function automatic logic [31:0] allocate_line(bit second, int pos, logic [31:0] addr,
                                                logic [31:0] now, ref int wb);
    logic [31:0] cost;
    cost = 0;
    if (line_dirty[pos]) begin
      cost = 32'(mem_dly);
      wb++;
    end
    line_tag[pos] = second ? addr >> 16 : addr >> 14;
    line_stamp[pos] = now;
    line_valid[pos] = 1'b1;
    line_dirty[pos] = 1'b0;
    return cost;
  endfunction

  function automatic access_result_t cache_access(bit wr, logic [31:0] addr,
                                                  logic [31:0] now);
    access_result_t r;
    logic [31:0] lat;
    int wb;
    int v1;
    int v2;
    int base;
    lat = 32'(l1_lat);
    wb = 0;
    r.first_miss = 1'b0;
    r.second_miss = 1'b0;
    if (!probe_level(1'b0, addr, now, v1)) begin
      r.first_miss = 1'b1;
      lat += 32'(l2_lat);
      if (!probe_level(1'b1, addr, now, v2)) begin
        r.second_miss = 1'b1;
        lat += allocate_line(1'b1, v2, addr, now, wb);
      end
      lat += allocate_line(1'b0, v1, addr, now, wb);
    end
    // A write dirties the first matching L1 way and drops the first matching
    // L2 way, both regardless of validity.
    if (wr) begin
      base = int'((addr >> 6) & 32'd255) * L1_WAYS;
      for (int i = 0; i < L1_WAYS; i++) begin
        if (line_tag[base + i] == (addr >> 14)) begin
          line_dirty[base + i] = 1'b1;
          break;
        end
      end
      base = L2_BASE + int'((addr >> 6) & 32'd1023) * L2_WAYS;
      for (int i = 0; i < L2_WAYS; i++) begin
        if (line_tag[base + i] == (addr >> 16)) begin
          line_valid[base + i] = 1'b0;
          break;
        end
      end
    end
    r.latency = lat[LAT_W-1:0];
    r.writebacks = wb[WB_W-1:0];
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each result word with the oldest pending prediction.
  always @(posedge clk) begin
    access_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: latency %0d", out_latency);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_latency !== exp_r.latency || out_first_miss !== exp_r.first_miss ||
            out_second_miss !== exp_r.second_miss || out_writebacks !== exp_r.writebacks) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp lat %0d m1 %b m2 %b wb %0d, got lat %0d m1 %b m2 %b wb %0d",
                     exp_r.latency, exp_r.first_miss, exp_r.second_miss, exp_r.writebacks,
                     out_latency, out_first_miss, out_second_miss, out_writebacks);
        end
      end
    end
  end

  // Send one access word; called and returning at a falling edge.
  task automatic send_access(bit wr, logic [31:0] addr, logic [31:0] now);
    in_valid = 1'b1;
    in_action = wr;
    in_address = addr;
    in_timestamp = now;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(cache_access(wr, addr, now));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      if (gap_max > 0) repeat ($urandom_range(0, gap_max)) @(negedge clk);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      REG_L1_LAT:    l1_lat = data[L1_LAT_W-1:0];
      REG_L2_LAT:    l2_lat = data[L2_LAT_W-1:0];
      REG_MEM_DELAY: mem_dly = data[MEM_DLY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 19) == 0) return $urandom();
    clock_now += $urandom_range(1, 20);
    return clock_now;
  endfunction

  // Mostly a few crowded sets so that hits, evictions and writebacks occur.
  task automatic send_random_access();
    logic [31:0] addr;
    if ($urandom_range(0, 99) < 85)
      addr = ($urandom_range(0, 23) << 14) | ($urandom_range(0, 3) << 6) | $urandom_range(0, 63);
    else
      addr = $urandom();
    send_access(1'($urandom_range(0, 1)), addr, next_stamp());
  endtask

  // Field extremes, writebacks and matches on never-written ways.
  task automatic test_directed();
    send_access(1'b0, 32'h0000_0000, 32'd0);
    send_access(1'b1, 32'h0000_0000, 32'd1);
    send_access(1'b0, 32'h0000_0004, 32'd2);
    for (int t = 1; t <= 4; t++) send_access(1'b0, t << 14, 32'd10 + t);
    send_access(1'b0, 32'h0000_0000, 32'd20);
    send_access(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFC0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h0000_4040, 32'd30);
    send_access(1'b0, 32'h0001_0040, 32'd30);
    send_access(1'b0, 32'h0000_4040, 32'd30);
    send_access(1'b1, 32'h0000_0080, 32'd0);
    send_access(1'b1, 32'h0004_0080, 32'd0);
    send_access(1'b0, 32'h0000_0080, 32'd40);
    send_access(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
    send_access(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_L1_LAT, 16'hFFFF);
    write_reg(REG_L2_LAT, 16'hFF00 | 16'd255);
    write_reg(REG_MEM_DELAY, 16'hFFFF);
    write_reg(2'd3, 16'h1234);
    for (int i = 0; i < 40; i++) send_random_access();
    wait_drained();
    write_reg(REG_L1_LAT, 16'h0000);
    write_reg(REG_L2_LAT, 16'h0000);
    write_reg(REG_MEM_DELAY, 16'h0000);
    for (int i = 0; i < 40; i++) send_random_access();
    wait_drained();
  endtask

  task automatic test_random_traffic(int n);
    for (int i = 0; i < n; i++) send_random_access();
  endtask

  // Hold the receiver off while the sender keeps pushing.
  task automatic test_backpressure();
    int saved;
    saved = gap_max;
    gap_max = 0;
    burst_left = 30;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_random_access();
    gap_max = saved;
    wait_drained();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_register_extremes();
    write_reg(REG_L1_LAT, CFG_DATA_W'($urandom()));
    write_reg(REG_L2_LAT, CFG_DATA_W'($urandom()));
    write_reg(REG_MEM_DELAY, CFG_DATA_W'($urandom()));
    stall_pct = 0;
    gap_max = 0;
    test_random_traffic(100);
    stall_pct = 40;
    gap_max = 6;
    test_random_traffic(150);
    test_backpressure();
    write_reg(REG_L1_LAT, 16'd1);
    write_reg(REG_L2_LAT, 16'd4);
    write_reg(REG_MEM_DELAY, 16'd200);
    stall_pct = 75;
    test_random_traffic(150);
    wait_drained();
    stall_pct = 10;
    gap_max = 2;
    test_random_traffic(140);
    wait_drained();
    repeat (30) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
